// ===== src/mva_pkg.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator package
// Shared constants, command and status types and the step table.
// ----------------------------------------------------------------------------
package mva_pkg;

   localparam int ACC_WIDTH     = 64;
   localparam int FRACTION_BITS = 16;
   localparam int PROD_SHIFT    = 32 - FRACTION_BITS;
   localparam int OUT_BITS      = 48;
   localparam int WIDE_W        = 130;
   localparam int MAG_W         = 129;
   localparam int DVS_W         = 33;
   localparam int DIV_STEPS     = MAG_W;
   localparam int OUT_RSH       = (FRACTION_BITS >= 16) ? FRACTION_BITS - 16 : 0;
   localparam int OUT_LSH       = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
   localparam int CONV_W        = ACC_WIDTH + 9;

   typedef logic signed [ACC_WIDTH-1:0] acc_type;

   localparam logic [1:0] KIND_MAC_SHIFT = 2'd0;
   localparam logic [1:0] KIND_MAC_DIV   = 2'd1;
   localparam logic [1:0] KIND_DIRECT    = 2'd2;
   localparam logic [1:0] KIND_END       = 2'd3;

   localparam logic [1:0] SRC_GRAD = 2'd0;
   localparam logic [1:0] SRC_MASS = 2'd1;
   localparam logic [1:0] SRC_GSUM = 2'd2;

   localparam logic SRC_POS  = 1'b0;
   localparam logic SRC_WPOS = 1'b1;

   localparam logic [1:0] VAL_Q    = 2'd0;
   localparam logic [1:0] VAL_GRAD = 2'd1;
   localparam logic [1:0] VAL_MOL  = 2'd2;

   localparam logic [1:0] TGT_MOL  = 2'd0;
   localparam logic [1:0] TGT_GSUM = 2'd1;
   localparam logic [1:0] TGT_WPOS = 2'd2;
   localparam logic [1:0] TGT_TOT  = 2'd3;

   localparam logic [1:0] GRP_ATOM = 2'd0;
   localparam logic [1:0] GRP_CORR = 2'd1;
   localparam logic [1:0] GRP_TOT  = 2'd2;

   typedef struct packed {
      logic       load;
      logic       clr_acc;
      logic       mul;
      logic       prod;
      logic [1:0] part;
      logic [1:0] a_src;
      logic       b_src;
      logic [1:0] ia;
      logic [1:0] ib;
      logic       scale;
      logic       shift_plus;
      logic       div_start;
      logic       half_div;
      logic       div_step;
      logic       val_load;
      logic [1:0] val_src;
      logic       write;
      logic [1:0] tgt;
      logic [2:0] tidx;
      logic       sub;
      logic       clear_mol;
      logic       load_out;
   } mva_cmd_type;

   typedef struct packed {
      logic eom;
      logic eos;
      logic mm_zero;
      logic out_busy;
   } mva_status_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [1:0] a_src;
      logic       b_src;
      logic [1:0] ia;
      logic [1:0] ib;
      logic       pair;
      logic       shift_plus;
      logic       half_div;
      logic [1:0] val_src;
      logic [1:0] tgt;
      logic [2:0] tidx;
      logic       sub;
      logic [1:0] grp;
   } mva_desc_type;

   localparam logic [4:0] LAST_STEP = 5'd24;

   function automatic logic [1:0] pair_a(input logic [1:0] k);
      unique case (k)
         2'd0, 2'd1: pair_a = 2'd0;
         default:    pair_a = 2'd1;
      endcase
   endfunction

   function automatic logic [1:0] pair_b(input logic [1:0] k);
      unique case (k)
         2'd0:    pair_b = 2'd1;
         default: pair_b = 2'd2;
      endcase
   endfunction

   function automatic mva_desc_type step_desc(input logic [4:0] step);
      mva_desc_type d;
      logic [4:0]   k;
      d = '0;
      d.kind = KIND_END;
      k = 5'd0;
      if (step < 5'd3) begin
         d.kind = KIND_MAC_SHIFT; d.a_src = SRC_GRAD; d.b_src = SRC_POS;
         d.ia = step[1:0]; d.ib = step[1:0]; d.val_src = VAL_Q;
         d.tgt = TGT_MOL; d.tidx = step[2:0]; d.sub = 1'b1; d.grp = GRP_ATOM;
      end else if (step < 5'd6) begin
         k = step - 5'd3;
         d.kind = KIND_MAC_SHIFT; d.a_src = SRC_GRAD; d.b_src = SRC_POS;
         d.ia = pair_a(k[1:0]); d.ib = pair_b(k[1:0]); d.pair = 1'b1;
         d.shift_plus = 1'b1; d.val_src = VAL_Q;
         d.tgt = TGT_MOL; d.tidx = step[2:0]; d.sub = 1'b1; d.grp = GRP_ATOM;
      end else if (step < 5'd9) begin
         k = step - 5'd6;
         d.kind = KIND_DIRECT; d.val_src = VAL_GRAD; d.ia = k[1:0];
         d.tgt = TGT_GSUM; d.tidx = k[2:0]; d.grp = GRP_ATOM;
      end else if (step < 5'd12) begin
         k = step - 5'd9;
         d.kind = KIND_MAC_SHIFT; d.a_src = SRC_MASS; d.b_src = SRC_POS;
         d.ia = k[1:0]; d.ib = k[1:0]; d.val_src = VAL_Q;
         d.tgt = TGT_WPOS; d.tidx = k[2:0]; d.grp = GRP_ATOM;
      end else if (step < 5'd15) begin
         k = step - 5'd12;
         d.kind = KIND_MAC_DIV; d.a_src = SRC_GSUM; d.b_src = SRC_WPOS;
         d.ia = k[1:0]; d.ib = k[1:0]; d.val_src = VAL_Q;
         d.tgt = TGT_MOL; d.tidx = k[2:0]; d.grp = GRP_CORR;
      end else if (step < 5'd18) begin
         k = step - 5'd15;
         d.kind = KIND_MAC_DIV; d.a_src = SRC_GSUM; d.b_src = SRC_WPOS;
         d.ia = pair_a(k[1:0]); d.ib = pair_b(k[1:0]); d.pair = 1'b1;
         d.half_div = 1'b1; d.val_src = VAL_Q;
         d.tgt = TGT_MOL; d.tidx = 3'(k + 5'd3); d.grp = GRP_CORR;
      end else if (step < LAST_STEP) begin
         k = step - 5'd18;
         d.kind = KIND_DIRECT; d.val_src = VAL_MOL;
         d.tgt = TGT_TOT; d.tidx = k[2:0]; d.grp = GRP_TOT;
      end
      return d;
   endfunction

endpackage

// ===== src/mva_datapath.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator datapath
// Input capture, shared 32x32 multiply-accumulate, rounding, divider,
// state registers and the result register.
// ----------------------------------------------------------------------------
module mva_datapath import mva_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  mva_cmd_type                cmd,
   output mva_status_type             status,
   input  logic signed [31:0]         req_grad_x,
   input  logic signed [31:0]         req_grad_y,
   input  logic signed [31:0]         req_grad_z,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_pos_z,
   input  logic [31:0]                req_atom_mass,
   input  logic [31:0]                req_molecule_mass,
   input  logic                       req_end_of_molecule,
   input  logic                       req_end_of_system,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_virial_xx,
   output logic signed [OUT_BITS-1:0] rsp_virial_yy,
   output logic signed [OUT_BITS-1:0] rsp_virial_zz,
   output logic signed [OUT_BITS-1:0] rsp_virial_xy,
   output logic signed [OUT_BITS-1:0] rsp_virial_xz,
   output logic signed [OUT_BITS-1:0] rsp_virial_yz
);

   localparam logic [MAG_W-1:0] POS_LIM = (MAG_W'(1) << (ACC_WIDTH - 1)) - MAG_W'(1);
   localparam logic [MAG_W-1:0] NEG_LIM = MAG_W'(1) << (ACC_WIDTH - 1);
   localparam logic [CONV_W-1:0] OUT_POS_LIM = (CONV_W'(1) << (OUT_BITS - 1)) - CONV_W'(1);
   localparam logic [CONV_W-1:0] OUT_NEG_LIM = CONV_W'(1) << (OUT_BITS - 1);
   localparam logic [CONV_W-1:0] OUT_HALF =
      (OUT_RSH == 0) ? CONV_W'(0) : (CONV_W'(1) << ((OUT_RSH == 0) ? 0 : OUT_RSH - 1));
   localparam acc_type ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
   localparam acc_type ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

   function automatic logic signed [OUT_BITS-1:0] out_conv(input acc_type v);
      logic [ACC_WIDTH-1:0] vmag;
      logic [CONV_W-1:0] mag;
      logic [CONV_W-1:0] q;
      logic [CONV_W-1:0] qc;
      vmag = v[ACC_WIDTH-1] ? -v : v;
      mag  = CONV_W'(vmag);
      q   = ((mag + OUT_HALF) >> OUT_RSH) << OUT_LSH;
      if (v[ACC_WIDTH-1]) begin
         qc = (q > OUT_NEG_LIM) ? OUT_NEG_LIM : q;
         out_conv = -qc[OUT_BITS-1:0];
      end else begin
         qc = (q > OUT_POS_LIM) ? OUT_POS_LIM : q;
         out_conv = qc[OUT_BITS-1:0];
      end
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      mag64 = a[63] ? 64'(-a) : 64'(a);
   endfunction

   logic signed [31:0]         grad_ff [3];
   logic signed [31:0]         pos_ff  [3];
   logic [31:0]                mass_ff;
   logic [31:0]                mm_ff;
   logic                       eom_ff;
   logic                       eos_ff;
   acc_type                    mol_ff  [6];
   acc_type                    gsum_ff [3];
   acc_type                    wpos_ff [3];
   acc_type                    tot_ff  [6];
   logic [WIDE_W-1:0]          acc_ff;
   logic [WIDE_W-1:0]          acc_in;
   logic [63:0]                pp_ff;
   logic [1:0]                 pp_sh_ff;
   logic                       pp_neg_ff;
   logic                       pp_vld_ff;
   logic [MAG_W-1:0]           q_ff;
   logic [MAG_W-1:0]           q_in;
   logic                       neg_ff;
   logic [DVS_W-1:0]           rem_ff;
   logic [DVS_W-1:0]           rem_in;
   logic [DVS_W-1:0]           dvs_ff;
   acc_type                    val_ff;
   acc_type                    val_in;
   logic                       rsp_valid_ff;
   logic signed [OUT_BITS-1:0] out_ff [6];

   logic [1:0]          a_idx;
   logic [1:0]          b_idx;
   logic signed [63:0]  a_val;
   logic signed [63:0]  b_val;
   logic [63:0]         a_mag;
   logic [63:0]         b_mag;
   logic [31:0]         a_half;
   logic [31:0]         b_half;
   logic [WIDE_W-1:0]   term;
   logic [WIDE_W-1:0]   acc_abs;
   logic [MAG_W-1:0]    mag;
   logic [WIDE_W-1:0]   rnd;
   logic [DVS_W-1:0]    dvs_new;
   logic [DVS_W:0]      rem_sh;
   logic [MAG_W-1:0]    q_cap;
   acc_type             cur;
   logic [ACC_WIDTH:0]  sum;
   acc_type             sum_sat;

   // Operand selection and partial product.
   always_comb begin
      a_idx = cmd.prod ? cmd.ib : cmd.ia;
      b_idx = cmd.prod ? cmd.ia : cmd.ib;
      unique case (cmd.a_src)
         SRC_GRAD: a_val = 64'(grad_ff[a_idx]);
         SRC_MASS: a_val = 64'({1'b0, mass_ff});
         default:  a_val = 64'(gsum_ff[a_idx]);
      endcase
      unique case (cmd.b_src)
         SRC_POS: b_val = 64'(pos_ff[b_idx]);
         default: b_val = 64'(wpos_ff[b_idx]);
      endcase
      a_mag  = mag64(a_val);
      b_mag  = mag64(b_val);
      a_half = cmd.part[1] ? a_mag[63:32] : a_mag[31:0];
      b_half = cmd.part[0] ? b_mag[63:32] : b_mag[31:0];
   end

   // Accumulation of the registered partial product.
   always_comb begin
      unique case (pp_sh_ff)
         2'd0:    term = WIDE_W'(pp_ff);
         2'd1:    term = WIDE_W'({pp_ff, 32'd0});
         default: term = WIDE_W'({pp_ff, 64'd0});
      endcase
      acc_in = acc_ff;
      if (cmd.clr_acc) begin
         acc_in = '0;
      end else if (pp_vld_ff) begin
         acc_in = pp_neg_ff ? acc_ff - term : acc_ff + term;
      end
   end

   // Rescaling: rounding shift or restoring division.
   always_comb begin
      acc_abs = acc_ff[WIDE_W-1] ? -acc_ff : acc_ff;
      mag     = acc_abs[MAG_W-1:0];
      if (cmd.shift_plus) begin
         rnd = (WIDE_W'(mag) + (WIDE_W'(1) << PROD_SHIFT)) >> (PROD_SHIFT + 1);
      end else begin
         rnd = (WIDE_W'(mag) + (WIDE_W'(1) << (PROD_SHIFT - 1))) >> PROD_SHIFT;
      end
      dvs_new = cmd.half_div ? {mm_ff, 1'b0} : {1'b0, mm_ff};
      rem_sh  = {rem_ff, q_ff[MAG_W-1]};
      q_in    = q_ff;
      rem_in  = rem_ff;
      if (cmd.scale) begin
         q_in = rnd[MAG_W-1:0];
      end else if (cmd.div_start) begin
         q_in   = mag + MAG_W'(dvs_new >> 1);
         rem_in = '0;
      end else if (cmd.div_step) begin
         if (rem_sh >= {1'b0, dvs_ff}) begin
            rem_in = DVS_W'(rem_sh - {1'b0, dvs_ff});
            q_in   = {q_ff[MAG_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh[DVS_W-1:0];
            q_in   = {q_ff[MAG_W-2:0], 1'b0};
         end
      end
   end

   // Saturated value and target update.
   always_comb begin
      if (neg_ff) begin
         q_cap = (q_ff > NEG_LIM) ? NEG_LIM : q_ff;
      end else begin
         q_cap = (q_ff > POS_LIM) ? POS_LIM : q_ff;
      end
      unique case (cmd.val_src)
         VAL_Q:    val_in = neg_ff ? -acc_type'(q_cap[ACC_WIDTH-1:0])
                                   : acc_type'(q_cap[ACC_WIDTH-1:0]);
         VAL_GRAD: val_in = ACC_WIDTH'(grad_ff[cmd.ia]);
         default:  val_in = mol_ff[cmd.tidx];
      endcase
      unique case (cmd.tgt)
         TGT_MOL:  cur = mol_ff[cmd.tidx];
         TGT_GSUM: cur = gsum_ff[cmd.tidx[1:0]];
         TGT_WPOS: cur = wpos_ff[cmd.tidx[1:0]];
         default:  cur = tot_ff[cmd.tidx];
      endcase
      if (cmd.sub) begin
         sum = {cur[ACC_WIDTH-1], cur} - {val_ff[ACC_WIDTH-1], val_ff};
      end else begin
         sum = {cur[ACC_WIDTH-1], cur} + {val_ff[ACC_WIDTH-1], val_ff};
      end
      if (sum[ACC_WIDTH] != sum[ACC_WIDTH-1]) begin
         sum_sat = sum[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
         sum_sat = sum[ACC_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         grad_ff[0] <= req_grad_x;
         grad_ff[1] <= req_grad_y;
         grad_ff[2] <= req_grad_z;
         pos_ff[0]  <= req_pos_x;
         pos_ff[1]  <= req_pos_y;
         pos_ff[2]  <= req_pos_z;
         mass_ff    <= req_atom_mass;
         mm_ff      <= req_molecule_mass;
         eom_ff     <= req_end_of_molecule;
         eos_ff     <= req_end_of_system;
      end
      pp_ff     <= a_half * b_half;
      pp_sh_ff  <= 2'(cmd.part[1]) + 2'(cmd.part[0]);
      pp_neg_ff <= a_val[63] ^ b_val[63];
      acc_ff    <= acc_in;
      q_ff      <= q_in;
      rem_ff    <= rem_in;
      if (cmd.scale || cmd.div_start) begin
         neg_ff <= acc_ff[WIDE_W-1];
      end
      if (cmd.div_start) begin
         dvs_ff <= dvs_new;
      end
      if (cmd.val_load) begin
         val_ff <= val_in;
      end
      if (cmd.load_out) begin
         for (int i = 0; i < 6; i++) begin
            out_ff[i] <= out_conv(tot_ff[i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 6; i++) begin
            mol_ff[i] <= '0;
            tot_ff[i] <= '0;
         end
         for (int i = 0; i < 3; i++) begin
            gsum_ff[i] <= '0;
            wpos_ff[i] <= '0;
         end
      end else begin
         pp_vld_ff <= cmd.mul;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cmd.write) begin
            unique case (cmd.tgt)
               TGT_MOL:  mol_ff[cmd.tidx] <= sum_sat;
               TGT_GSUM: gsum_ff[cmd.tidx[1:0]] <= sum_sat;
               TGT_WPOS: wpos_ff[cmd.tidx[1:0]] <= sum_sat;
               default:  tot_ff[cmd.tidx] <= sum_sat;
            endcase
         end
         if (cmd.clear_mol) begin
            for (int i = 0; i < 6; i++) begin
               mol_ff[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
               gsum_ff[i] <= '0;
               wpos_ff[i] <= '0;
            end
         end
         if (cmd.load_out) begin
            for (int i = 0; i < 6; i++) begin
               tot_ff[i] <= '0;
            end
         end
      end
   end

   assign status.eom      = eom_ff;
   assign status.eos      = eos_ff;
   assign status.mm_zero  = (mm_ff == 32'd0);
   assign status.out_busy = rsp_valid_ff;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_virial_xx = out_ff[0];
   assign rsp_virial_yy = out_ff[1];
   assign rsp_virial_zz = out_ff[2];
   assign rsp_virial_xy = out_ff[3];
   assign rsp_virial_xz = out_ff[4];
   assign rsp_virial_yz = out_ff[5];

endmodule

// ===== src/mva_controller.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator controller
// Walks the step table for one atom and issues datapath commands.
// ----------------------------------------------------------------------------
module mva_controller import mva_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  mva_status_type status,
   output mva_cmd_type    cmd
);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_DISPATCH = 3'd1;
   localparam logic [2:0] ST_MUL      = 3'd2;
   localparam logic [2:0] ST_DRAIN    = 3'd3;
   localparam logic [2:0] ST_SCALE    = 3'd4;
   localparam logic [2:0] ST_DIV      = 3'd5;
   localparam logic [2:0] ST_VALUE    = 3'd6;
   localparam logic [2:0] ST_WRITE    = 3'd7;

   logic [2:0]   state_ff;
   logic [2:0]   state_in;
   logic [4:0]   step_ff;
   logic [4:0]   step_in;
   logic [7:0]   cnt_ff;
   logic [7:0]   cnt_in;
   mva_desc_type desc;
   logic         closing;
   logic         skip;
   logic         last_mul;

   always_comb begin
      desc     = step_desc(step_ff);
      closing  = status.eom || status.eos;
      skip     = ((desc.grp == GRP_CORR) && !(closing && !status.mm_zero)) ||
                 ((desc.grp == GRP_TOT) && !closing);
      last_mul = desc.pair ? (cnt_ff[2:0] == 3'd7) : (cnt_ff[1:0] == 2'd3);

      state_in = state_ff;
      step_in  = step_ff;
      cnt_in   = cnt_ff;

      cmd            = '0;
      cmd.prod       = cnt_ff[2];
      cmd.part       = cnt_ff[1:0];
      cmd.a_src      = desc.a_src;
      cmd.b_src      = desc.b_src;
      cmd.ia         = desc.ia;
      cmd.ib         = desc.ib;
      cmd.shift_plus = desc.shift_plus;
      cmd.half_div   = desc.half_div;
      cmd.val_src    = desc.val_src;
      cmd.tgt        = desc.tgt;
      cmd.tidx       = desc.tidx;
      cmd.sub        = desc.sub;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            if (desc.kind == KIND_END) begin
               if (!(status.eos && status.out_busy)) begin
                  cmd.clear_mol = closing;
                  cmd.load_out  = status.eos;
                  state_in      = ST_IDLE;
               end
            end else if (skip) begin
               step_in = step_ff + 5'd1;
            end else if (desc.kind == KIND_DIRECT) begin
               state_in = ST_VALUE;
            end else begin
               cmd.clr_acc = 1'b1;
               cnt_in      = '0;
               state_in    = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.mul = 1'b1;
            cnt_in  = cnt_ff + 8'd1;
            if (last_mul) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_SCALE;
         end
         ST_SCALE: begin
            if (desc.kind == KIND_MAC_DIV) begin
               cmd.div_start = 1'b1;
               cnt_in        = '0;
               state_in      = ST_DIV;
            end else begin
               cmd.scale = 1'b1;
               state_in  = ST_VALUE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = cnt_ff + 8'd1;
            if (cnt_ff == 8'(DIV_STEPS - 1)) begin
               state_in = ST_VALUE;
            end
         end
         ST_VALUE: begin
            cmd.val_load = 1'b1;
            state_in     = ST_WRITE;
         end
         default: begin
            cmd.write = 1'b1;
            step_in   = step_ff + 5'd1;
            state_in  = ST_DISPATCH;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         cnt_ff   <= cnt_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

endmodule

// ===== src/molecular_virial_accumulator_top.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator
// Accumulates molecular virial tensors over a stream of atoms.
// ----------------------------------------------------------------------------
// Atoms enter on the req_ channel, grouped by molecule, with end flags for the
// molecule and for the system. Each atom is worked through a shared 32x32
// multiplier, one partial product per cycle, followed by a rounding step and
// a saturating update of the per-molecule sums. When the molecule mass is not
// zero, the last atom of a molecule adds the six correction terms, each
// through a bit-serial divider of 129 steps; the last atom then folds the
// molecule into the running totals. Only one atom is in work at a time;
// req_ready is high while the block waits for the next atom. On the last
// atom of the system the six totals are converted to signed Q32.16 with
// saturation, placed in the result register and cleared. The result is
// offered on the rsp_ channel until a transfer takes place; the block keeps
// accepting atoms meanwhile and only holds back at the next end of system
// while the earlier result is still waiting. Reset clears all sums and drops
// rsp_valid.
// ----------------------------------------------------------------------------
module molecular_virial_accumulator_top import mva_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic signed [31:0]         req_grad_x,
   input  logic signed [31:0]         req_grad_y,
   input  logic signed [31:0]         req_grad_z,
   input  logic signed [31:0]         req_pos_x,
   input  logic signed [31:0]         req_pos_y,
   input  logic signed [31:0]         req_pos_z,
   input  logic [31:0]                req_atom_mass,
   input  logic [31:0]                req_molecule_mass,
   input  logic                       req_end_of_molecule,
   input  logic                       req_end_of_system,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic signed [OUT_BITS-1:0] rsp_virial_xx,
   output logic signed [OUT_BITS-1:0] rsp_virial_yy,
   output logic signed [OUT_BITS-1:0] rsp_virial_zz,
   output logic signed [OUT_BITS-1:0] rsp_virial_xy,
   output logic signed [OUT_BITS-1:0] rsp_virial_xz,
   output logic signed [OUT_BITS-1:0] rsp_virial_yz
);

   mva_cmd_type    cmd;
   mva_status_type status;

   mva_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mva_datapath u_dp (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_grad_x          (req_grad_x),
      .req_grad_y          (req_grad_y),
      .req_grad_z          (req_grad_z),
      .req_pos_x           (req_pos_x),
      .req_pos_y           (req_pos_y),
      .req_pos_z           (req_pos_z),
      .req_atom_mass       (req_atom_mass),
      .req_molecule_mass   (req_molecule_mass),
      .req_end_of_molecule (req_end_of_molecule),
      .req_end_of_system   (req_end_of_system),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_virial_xx       (rsp_virial_xx),
      .rsp_virial_yy       (rsp_virial_yy),
      .rsp_virial_zz       (rsp_virial_zz),
      .rsp_virial_xy       (rsp_virial_xy),
      .rsp_virial_xz       (rsp_virial_xz),
      .rsp_virial_yz       (rsp_virial_yz)
   );

endmodule

// ===== src/mva_checker.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator checker
// Port-level properties of the accumulator, attached by bind.
// ----------------------------------------------------------------------------
module mva_checker import mva_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_valid,
   input logic                       req_ready,
   input logic                       req_end_of_system,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [OUT_BITS-1:0] rsp_virial_xx,
   input logic signed [OUT_BITS-1:0] rsp_virial_yz
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_virial_xx) &&
      $stable(rsp_virial_yz))
      else $error("result changed while stalled");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second atom taken while one is in work");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result pending after reset");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_end_of_system && !rsp_valid |=> !rsp_valid)
      else $error("result without end of system");

endmodule

bind molecular_virial_accumulator_top mva_checker u_mva_checker (.*);

// ===== verif/molecular_virial_accumulator_top_test.sv =====
// ----------------------------------------------------------------------------
// Molecular virial accumulator testbench
// Streams systems of atoms grouped into molecules through the block. A
// directed table covers field extremes, saturation, zero molecule mass and a
// system end without a molecule end. Random systems follow. Every result is
// compared with a bit-exact prediction, and both channels idle at random.
// ----------------------------------------------------------------------------
module molecular_virial_accumulator_top_test;
   timeunit 1ns;
   timeprecision 1ps;
   import mva_pkg::*;

   typedef logic signed [191:0] big_type;
   typedef logic [5:0][OUT_BITS-1:0] virial_type;

   typedef struct {
      logic signed [31:0] gx, gy, gz, px, py, pz;
      logic [31:0]        am, mm;
      logic               eom, eos;
   } atom_type;

   typedef struct {
      atom_type            a;
      bit                  known;
      logic [OUT_BITS-1:0] kval;
   } row_type;

   localparam longint CYCLE_LIMIT = 64'd8_000_000;
   localparam logic [OUT_BITS-1:0] OUT_MAX = {1'b0, {(OUT_BITS-1){1'b1}}};
   localparam logic [OUT_BITS-1:0] OUT_MIN = {1'b1, {(OUT_BITS-1){1'b0}}};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [31:0] req_grad_x = '0, req_grad_y = '0, req_grad_z = '0;
   logic signed [31:0] req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic [31:0] req_atom_mass = '0, req_molecule_mass = '0;
   logic req_end_of_molecule = 1'b0, req_end_of_system = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [OUT_BITS-1:0] rsp_virial_xx, rsp_virial_yy, rsp_virial_zz;
   logic signed [OUT_BITS-1:0] rsp_virial_xy, rsp_virial_xz, rsp_virial_yz;

   molecular_virial_accumulator_top dut (.*);

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   longint mol_tensor[6], grad_sum[3], weighted_pos[3], total_tensor[6];
   virial_type pending_virials[$];
   int errors = 0;
   longint cycles = 0;
   row_type table_rows[$];

   function automatic longint round_div(big_type a, big_type d, int bits);
      logic [191:0] mag, q, lim;
      bit neg;
      neg = a < 0;
      mag = neg ? -a : a;
      q = (mag + (d >> 1)) / d;
      lim = (192'd1 << (bits - 1)) - (neg ? 0 : 1);
      if (q > lim) q = lim;
      return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      return round_div(big_type'(a) + big_type'(b), 1, ACC_WIDTH);
   endfunction

   task automatic virial_predict(input atom_type a, output bit emit, output virial_type r);
      int pa[3] = '{0, 0, 1};
      int pb[3] = '{1, 2, 2};
      longint g[3], p[3], c;
      big_type s;
      g = '{longint'(a.gx), longint'(a.gy), longint'(a.gz)};
      p = '{longint'(a.px), longint'(a.py), longint'(a.pz)};
      for (int i = 0; i < 3; i++) begin
         c = round_div(big_type'(g[i]) * big_type'(p[i]), big_type'(1) << PROD_SHIFT,
                       ACC_WIDTH);
         mol_tensor[i] = sat_sum(mol_tensor[i], -c);
      end
      for (int i = 0; i < 3; i++) begin
         s = big_type'(g[pa[i]]) * big_type'(p[pb[i]])
           + big_type'(g[pb[i]]) * big_type'(p[pa[i]]);
         c = round_div(s, big_type'(1) << (PROD_SHIFT + 1), ACC_WIDTH);
         mol_tensor[3+i] = sat_sum(mol_tensor[3+i], -c);
      end
      for (int i = 0; i < 3; i++) begin
         grad_sum[i] = sat_sum(grad_sum[i], g[i]);
         c = round_div(big_type'({32'd0, a.am}) * big_type'(p[i]),
                       big_type'(1) << PROD_SHIFT, ACC_WIDTH);
         weighted_pos[i] = sat_sum(weighted_pos[i], c);
      end
      if (a.eom || a.eos) begin
         if (a.mm != 0) begin
            for (int i = 0; i < 3; i++) begin
               c = round_div(big_type'(grad_sum[i]) * big_type'(weighted_pos[i]),
                             big_type'({32'd0, a.mm}), ACC_WIDTH);
               mol_tensor[i] = sat_sum(mol_tensor[i], c);
            end
            for (int i = 0; i < 3; i++) begin
               s = big_type'(grad_sum[pa[i]]) * big_type'(weighted_pos[pb[i]])
                 + big_type'(grad_sum[pb[i]]) * big_type'(weighted_pos[pa[i]]);
               c = round_div(s, big_type'({32'd0, a.mm}) * 2, ACC_WIDTH);
               mol_tensor[3+i] = sat_sum(mol_tensor[3+i], c);
            end
         end
         for (int i = 0; i < 6; i++) begin
            total_tensor[i] = sat_sum(total_tensor[i], mol_tensor[i]);
            mol_tensor[i] = 0;
         end
         for (int i = 0; i < 3; i++) begin
            grad_sum[i] = 0;
            weighted_pos[i] = 0;
         end
      end
      emit = a.eos;
      r = '0;
      if (a.eos) begin
         for (int i = 0; i < 6; i++) begin
            r[i] = OUT_BITS'(round_div(big_type'(total_tensor[i]) * (big_type'(1) << OUT_LSH),
                                       big_type'(1) << OUT_RSH, OUT_BITS));
            total_tensor[i] = 0;
         end
      end
   endtask

   function automatic logic signed [31:0] pick_signed();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0: return 32'sh7FFF_FFFF;
               1: return 32'sh8000_0000;
               2: return 32'sd0;
               default: return -32'sd1;
            endcase
         end
         2: return $signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000;
         default: return $signed($urandom_range(0, 32'h0007_FFFF)) - 32'sh0004_0000;
      endcase
   endfunction

   function automatic logic [31:0] pick_mass();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
         default: return $urandom_range(32'h0000_8000, 32'h0020_0000);
      endcase
   endfunction

   function automatic atom_type random_atom(bit eom, bit eos);
      atom_type a;
      a.gx = pick_signed(); a.gy = pick_signed(); a.gz = pick_signed();
      a.px = pick_signed(); a.py = pick_signed(); a.pz = pick_signed();
      a.am = pick_mass();
      a.mm = ($urandom_range(0, 39) == 0) ? 32'd0 : pick_mass();
      if (a.mm == 0 && $urandom_range(0, 3) != 0) a.mm = 32'd1;
      a.eom = eom;
      a.eos = eos;
      return a;
   endfunction

   function automatic atom_type fixed_atom(logic signed [31:0] g, logic signed [31:0] p,
                                           logic [31:0] am, logic [31:0] mm, bit eom,
                                           bit eos);
      atom_type a;
      a.gx = g; a.gy = g; a.gz = g;
      a.px = p; a.py = p; a.pz = p;
      a.am = am; a.mm = mm; a.eom = eom; a.eos = eos;
      return a;
   endfunction

   task automatic add_row(atom_type a, bit known = 0, logic [OUT_BITS-1:0] kval = '0);
      row_type r;
      r.a = a; r.known = known; r.kval = kval;
      table_rows.push_back(r);
   endtask

   function automatic int pick_gap();
      int k;
      k = $urandom_range(0, 19);
      if (k < 10) return 0;
      if (k < 18) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_atom(atom_type a, bit known, logic [OUT_BITS-1:0] kval);
      bit emit;
      virial_type r;
      int gap;
      req_valid <= 1'b1;
      req_grad_x <= a.gx; req_grad_y <= a.gy; req_grad_z <= a.gz;
      req_pos_x <= a.px; req_pos_y <= a.py; req_pos_z <= a.pz;
      req_atom_mass <= a.am; req_molecule_mass <= a.mm;
      req_end_of_molecule <= a.eom; req_end_of_system <= a.eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      virial_predict(a, emit, r);
      if (emit) pending_virials.push_back(known ? {6{kval}} : r);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   int ready_hold = 0;
   always @(posedge clock) begin
      if (ready_hold == 0) begin
         case ($urandom_range(0, 9))
            0, 1, 2: begin rsp_ready <= 1'b0; ready_hold = $urandom_range(1, 4); end
            3: begin rsp_ready <= 1'b0; ready_hold = $urandom_range(50, 400); end
            default: begin rsp_ready <= 1'b1; ready_hold = $urandom_range(1, 200); end
         endcase
      end else begin
         ready_hold--;
      end
   end

   always @(posedge clock) begin
      virial_type got, want;
      if (!reset && rsp_valid && rsp_ready) begin
         got = {rsp_virial_yz, rsp_virial_xz, rsp_virial_xy,
                rsp_virial_zz, rsp_virial_yy, rsp_virial_xx};
         if (pending_virials.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
         end else begin
            want = pending_virials.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (got[i] !== want[i]) begin
                  $error("virial_%s expected %0d got %0d",
                         i == 0 ? "xx" : i == 1 ? "yy" : i == 2 ? "zz" :
                         i == 3 ? "xy" : i == 4 ? "xz" : "yz",
                         $signed(want[i]), $signed(got[i]));
                  errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("molecular_virial_accumulator_top_test: errors");
         $finish;
      end
   end

   initial begin
      int sent, n_mol, n_atoms;
      bit last_mol, broken;
      foreach (mol_tensor[i]) begin mol_tensor[i] = 0; total_tensor[i] = 0; end
      foreach (grad_sum[i]) begin grad_sum[i] = 0; weighted_pos[i] = 0; end

      add_row(fixed_atom(0, 0, 0, 0, 1, 1), 1, '0);
      for (int i = 0; i < 4; i++)
         add_row(fixed_atom(32'sh8000_0000, 32'sh7FFF_FFFF, 0, 32'hFFFF_FFFF, i == 3, i == 3),
                 i == 3, OUT_MAX);
      for (int i = 0; i < 4; i++)
         add_row(fixed_atom(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 0, 1, 0, i == 3), i == 3, OUT_MIN);
      add_row(fixed_atom(32'sh7FFF_FFFF, 32'sh8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
      add_row(fixed_atom(-32'sd1, 32'sh0001_0000, 32'h0001_0000, 32'd0, 1, 0));
      add_row(fixed_atom(32'sh0001_8000, -32'sh0002_0000, 32'h0002_0000, 32'h0003_0000, 0, 0));
      add_row(fixed_atom(32'sh0000_8000, 32'sh0000_0001, 32'hFFFF_FFFF, 32'h0003_0000, 1, 1));
      add_row(fixed_atom(32'sh1234_5678, -32'sh0765_4321, 32'h0000_0001, 32'd1, 1, 0));
      add_row(fixed_atom(-32'sh0000_0003, 32'sh7FFF_FFFF, 32'h8000_0000, 32'd1, 0, 1));
      add_row(fixed_atom(32'sh5555_5555, 32'shAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1, 1));

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (table_rows[i]) send_atom(table_rows[i].a, table_rows[i].known, table_rows[i].kval);

      sent = 0;
      while (sent < 1800) begin
         n_mol = $urandom_range(1, 4);
         for (int m = 0; m < n_mol; m++) begin
            last_mol = (m == n_mol - 1);
            n_atoms = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 4);
            broken = $urandom_range(0, 9) == 0;
            for (int k = 0; k < n_atoms; k++) begin
               if (k == n_atoms - 1)
                  send_atom(random_atom(!(last_mol && broken), last_mol), 0, '0);
               else
                  send_atom(random_atom(0, 0), 0, '0);
               sent++;
            end
         end
      end
      req_valid <= 1'b0;

      while (pending_virials.size() != 0) @(posedge clock);
      repeat (1200) @(posedge clock);
      if (errors == 0 && pending_virials.size() == 0)
         $display("molecular_virial_accumulator_top_test: clean");
      else
         $display("molecular_virial_accumulator_top_test: errors");
      $finish;
   end

endmodule
